>>> rtl/core/sm3_pkg.sv
// SM3 engine package: initial value words, round constants and the
// compression helper functions. No dependencies.
`default_nettype none
package sm3_pkg;

  localparam logic [31:0] TJ_LOW  = 32'h79cc4519;
  localparam logic [31:0] TJ_HIGH = 32'h7a879d8a;
  localparam logic [31:0] PAD_ONE = 32'h80000000;

  typedef logic [31:0] word_t;

  function automatic word_t iv_word(input logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0: r = 32'h7380166F;
      3'd1: r = 32'h4914B2B9;
      3'd2: r = 32'h172442D7;
      3'd3: r = 32'hDA8A0600;
      3'd4: r = 32'hA96F30BC;
      3'd5: r = 32'h163138AA;
      3'd6: r = 32'hE38DEE4D;
      default: r = 32'hB0FB0E4E;
    endcase
    return r;
  endfunction

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/sm3_compress.sv
// SM3 compression: one round per cycle over a 16-word block held in a
// synchronous memory, with the message expansion kept in a 16-word window.
// Depends on sm3_pkg.
`default_nettype none
module sm3_compress (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire sm3_pkg::word_t blk_rdata,
  output logic [3:0]          blk_raddr,
  input  wire sm3_pkg::word_t cv_in [8],
  output sm3_pkg::word_t      cv_out [8],
  output logic                done
);
  import sm3_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RND  = 2'd2;

  logic [1:0] state;
  logic [4:0] lcnt;
  logic [5:0] rnd;
  word_t      w [16];
  word_t      a, b, c, d, e, f, g, h;
  word_t      wnew, tj, a12, ss1, ss2, ffv, ggv, tt1, tt2;

  // Expand the next window word and run one round
  always_comb begin
    wnew = perm1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
    tj   = rnd[5:4] == 2'd0 ? TJ_LOW : TJ_HIGH;
    a12  = rotl(a, 5'd12);
    ss1  = rotl(a12 + e + rotl(tj, rnd[4:0]), 5'd7);
    ss2  = ss1 ^ a12;
    if (rnd[5:4] == 2'd0) begin
      ffv = a ^ b ^ c;
      ggv = e ^ f ^ g;
    end else begin
      ffv = (a & b) | (a & c) | (b & c);
      ggv = (e & f) | (~e & g);
    end
    tt1 = ffv + d + ss2 + (w[0] ^ w[4]);
    tt2 = ggv + h + ss1 + w[0];
  end

  assign blk_raddr = lcnt[3:0];
  assign cv_out[0] = cv_in[0] ^ a;
  assign cv_out[1] = cv_in[1] ^ b;
  assign cv_out[2] = cv_in[2] ^ c;
  assign cv_out[3] = cv_in[3] ^ d;
  assign cv_out[4] = cv_in[4] ^ e;
  assign cv_out[5] = cv_in[5] ^ f;
  assign cv_out[6] = cv_in[6] ^ g;
  assign cv_out[7] = cv_in[7] ^ h;

  // Load block words one per cycle, then advance the rounds
  always_ff @(posedge clk) begin
    done <= !rst && state == ST_RND && rnd == 6'd63;
    if (rst) begin
      state <= ST_IDLE;
      lcnt  <= '0;
      rnd   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_LOAD;
            lcnt  <= 5'd1;
          end
        end
        ST_LOAD: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= blk_rdata;
          // Park the read address on word 0 for the next block
          lcnt  <= (lcnt == 5'd16) ? 5'd0 : lcnt + 5'd1;
          if (lcnt == 5'd16) begin
            state <= ST_RND;
            rnd   <= '0;
            {a, b, c, d} <= {cv_in[0], cv_in[1], cv_in[2], cv_in[3]};
            {e, f, g, h} <= {cv_in[4], cv_in[5], cv_in[6], cv_in[7]};
          end
        end
        ST_RND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wnew;
          d <= c; c <= rotl(b, 5'd9); b <= a; a <= tt1;
          h <= g; g <= rotl(f, 5'd19); f <= e; e <= perm0(tt2);
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/sm3_hash_bit_length_unit.sv
// SM3 hash engine top level: word intake, padding sequencer, block memory
// and digest output. Depends on sm3_pkg and sm3_compress.
//
// Usage: present message words on message_word with valid_bits and is_last;
// a request is taken when valid is high and stall is low. Every word but the
// last counts as 32 bits. The last word's valid_bits (0..32) sets the tail.
// A plain word is written into the block memory; the sixteenth word of a
// block starts a compression (a start, a load of the 16 block words, 64
// rounds, then the store of the result), during which stall is held high.
// A last word adds padding words one per cycle, one or two compressions, then
// eight digest requests on the output channel, word_index 0 first, last_word
// on the eighth. While the receiver stalls, the current digest word holds.
// The engine then reloads the initial value and takes a new message.
// Reset returns the chaining value to the initial value and clears the bit
// count and fill position; the block memory needs no clearing.
`default_nettype none
module sm3_hash_bit_length_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] message_word,
  input  wire  [5:0]  valid_bits,
  input  wire         is_last,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sm3_pkg::*;

  localparam logic [2:0] ST_IN   = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_PAD  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  logic [2:0]  state;
  logic        pad_mode;
  logic        pad_one;
  logic        pad_done_q;
  logic        len_skip;
  logic [63:0] bit_count;
  logic [3:0]  fill;
  word_t       cv [8];
  word_t       cv_new [8];
  word_t       blk_mem [16];
  word_t       blk_rdata;
  logic [3:0]  blk_raddr;
  logic        wr_en;
  logic [3:0]  wr_addr;
  word_t       wr_data;
  logic        cmp_start;
  logic        cmp_done;
  logic        accept;
  logic [5:0]  vb;
  word_t       mask, tail;
  logic [63:0] count_next;

  sm3_compress u_cmp (
    .clk(clk), .rst(rst), .start(cmp_start), .blk_rdata(blk_rdata),
    .blk_raddr(blk_raddr), .cv_in(cv), .cv_out(cv_new), .done(cmp_done)
  );

  // Block memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) blk_mem[wr_addr] <= wr_data;
    blk_rdata <= blk_mem[blk_raddr];
  end

  assign in_stall = state != ST_IN;
  assign accept   = in_valid && !in_stall;

  // Clamp the tail length and build the masked last word, with its 1 bit when under 32 bits
  always_comb begin
    vb   = (!is_last || valid_bits > 6'd32) ? 6'd32 : valid_bits;
    mask = vb == 6'd0 ? 32'h0 : ~(32'hFFFFFFFF >> vb[4:0]);
    if (vb == 6'd32) mask = 32'hFFFFFFFF;
    tail = (message_word & mask) | (vb == 6'd32 ? 32'h0 : (PAD_ONE >> vb[4:0]));
    count_next = bit_count + {58'd0, vb};
  end

  // Write sources: input word, or the padding sequencer
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill;
    wr_data = message_word;
    if (state == ST_IN && accept) begin
      wr_en   = 1'b1;
      wr_data = is_last ? tail : message_word;
    end else if (state == ST_PAD) begin
      wr_en = 1'b1;
      if (pad_one)              wr_data = PAD_ONE;
      else if (fill == 4'd14 && pad_mode && !len_skip) wr_data = bit_count[63:32];
      else if (fill == 4'd15 && pad_mode && !len_skip) wr_data = bit_count[31:0];
      else                      wr_data = '0;
    end
  end

  assign out_valid   = state == ST_OUT;
  assign digest_word = cv[word_index];
  assign last_word   = word_index == 3'd7;

  // Sequencer: intake, padding, compression and digest output
  always_ff @(posedge clk) begin
    cmp_start <= !rst && fill == 4'd15 &&
                 ((state == ST_IN && accept) || state == ST_PAD);
    if (rst) begin
      state      <= ST_IN;
      pad_mode   <= 1'b0;
      pad_one    <= 1'b0;
      bit_count  <= '0;
      fill       <= '0;
      word_index <= '0;
      for (int i = 0; i < 8; i++) cv[i] <= iv_word(3'(i));
    end else begin
      case (state)
        ST_IN: begin
          if (accept) begin
            bit_count <= count_next;
            fill      <= fill + 4'd1;
            if (is_last) begin
              pad_mode <= 1'b1;
              pad_one  <= vb == 6'd32;
              if (fill == 4'd15) begin
                state <= ST_CMP;
              end else begin
                state <= ST_PAD;
              end
            end else if (fill == 4'd15) begin
              state <= ST_CMP;
            end
          end
        end
        ST_PAD: begin
          pad_one <= 1'b0;
          fill    <= fill + 4'd1;
          // Close the block once word 15 is written
          if (fill == 4'd15) begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (cmp_done) begin
            for (int i = 0; i < 8; i++) cv[i] <= cv_new[i];
            if (!pad_mode) state <= ST_IN;
            else if (pad_done_q) state <= ST_OUT;
            else state <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            word_index <= word_index + 3'd1;
            if (word_index == 3'd7) begin
              state     <= ST_IN;
              pad_mode  <= 1'b0;
              bit_count <= '0;
              fill      <= '0;
              for (int i = 0; i < 8; i++) cv[i] <= iv_word(3'(i));
            end
          end
        end
        default: state <= ST_IN;
      endcase
    end
  end

  // Track whether the length words have gone into the block being compressed
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_done_q <= 1'b0;
    end else if (state == ST_OUT) begin
      pad_done_q <= 1'b0;
    end else if (state == ST_PAD && fill == 4'd15 && !len_skip) begin
      pad_done_q <= 1'b1;
    end
  end

  // Length slots are skipped when the 1 bit or tail sits in words 14/15
  always_ff @(posedge clk) begin
    if (rst) begin
      len_skip <= 1'b0;
    end else if (state == ST_IN && accept && is_last) begin
      len_skip <= (fill == 4'd14 && vb != 6'd32) || fill == 4'd15 ||
                  (fill == 4'd14 && vb == 6'd32) || (fill == 4'd13 && vb == 6'd32);
    end else if (state == ST_CMP && cmp_done) begin
      len_skip <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> sim/sm3_digest_checker.sv
// Digest checker for the SM3 hash engine: watches both channels, rebuilds
// each digest with its own SM3 model and compares word by word. Uses sm3_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sm3_digest_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [31:0] message_word,
  input  wire  [5:0]  valid_bits,
  input  wire         is_last,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [31:0] digest_word,
  input  wire  [2:0]  word_index,
  input  wire         last_word,
  output int          fail_count,
  output int          pending_words,
  output int          digests_seen
);
  import sm3_pkg::*;

  typedef struct packed {
    word_t      dword;
    logic [2:0] idx;
    logic       lst;
  } digest_req_t;

  word_t       chain[8];
  word_t       blk[16];
  logic [63:0] bit_total;
  logic [3:0]  fill;
  digest_req_t digest_q[$];

  function automatic word_t rol(word_t x, int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic word_t p0f(word_t x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic word_t p1f(word_t x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  // One SM3 compression of the gathered block into the chaining value
  task automatic compress_blk();
    word_t w[68];
    word_t a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ffv, ggv, tt1, tt2;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++)
      w[j] = p1f(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? 32'h79cc4519 : 32'h7a879d8a;
      a12 = rol(a, 12);
      ss1 = rol(a12 + e + rol(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ffv = a ^ b ^ c;
        ggv = e ^ f ^ g;
      end else begin
        ffv = (a & b) | (a & c) | (b & c);
        ggv = (e & f) | (~e & g);
      end
      tt1 = ffv + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = ggv + h + ss1 + w[j];
      d = c; c = rol(b, 9); b = a; a = tt1;
      h = g; g = rol(f, 19); f = e; e = p0f(tt2);
    end
    chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
    chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
  endtask

  task automatic put_word(word_t wd);
    blk[fill] = wd;
    fill = fill + 4'd1;
    if (fill == 4'd0) compress_blk();
  endtask

  task automatic restart_hash();
    for (int k = 0; k < 8; k++) chain[k] = 32'h0;
    chain[0] = 32'h7380166F; chain[1] = 32'h4914B2B9;
    chain[2] = 32'h172442D7; chain[3] = 32'hDA8A0600;
    chain[4] = 32'hA96F30BC; chain[5] = 32'h163138AA;
    chain[6] = 32'hE38DEE4D; chain[7] = 32'hB0FB0E4E;
    bit_total = 64'd0;
    fill = 4'd0;
  endtask

  // Absorb one request; on the last word pad, finish and queue the digest
  task automatic absorb_word(word_t wd, logic [5:0] vb_in, logic lst);
    int    vb;
    word_t mask;
    digest_req_t r;
    if (!lst) begin
      bit_total += 64'd32;
      put_word(wd);
      return;
    end
    vb = (vb_in > 6'd32) ? 32 : int'(vb_in);
    bit_total += 64'(vb);
    if (vb == 32) begin
      put_word(wd);
      put_word(PAD_ONE);
    end else begin
      mask = (vb == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - vb));
      put_word((wd & mask) | (PAD_ONE >> vb));
    end
    if (fill > 4'd14) while (fill != 4'd0) put_word(32'h0);
    while (fill < 4'd14) put_word(32'h0);
    put_word(bit_total[63:32]);
    put_word(bit_total[31:0]);
    for (int k = 0; k < 8; k++) begin
      r.dword = chain[k];
      r.idx   = 3'(k);
      r.lst   = (k == 7);
      digest_q.push_back(r);
    end
    restart_hash();
  endtask

  initial begin
    fail_count = 0;
    digests_seen = 0;
    restart_hash();
  end

  assign pending_words = digest_q.size();

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    digest_req_t exp_r;
    if (rst) begin
      restart_hash();
      digest_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected digest word %h idx %0d", $time, digest_word,
                     word_index);
        end else begin
          exp_r = digest_q.pop_front();
          if (digest_word !== exp_r.dword || word_index !== exp_r.idx ||
              last_word !== exp_r.lst) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b", $time,
                       exp_r.dword, exp_r.idx, exp_r.lst, digest_word, word_index,
                       last_word);
          end
          if (exp_r.lst) digests_seen++;
        end
      end
      if (in_valid && !in_stall) absorb_word(message_word, valid_bits, is_last);
    end
  end
endmodule
`default_nettype wire

>>> sim/tb_sm3_hash_bit_length_unit.sv
// Testbench top for the SM3 hash engine: drives messages with random gaps and
// stalls, and gives the verdict. Uses sm3_digest_checker and the engine.
`timescale 1ns / 1ps
`default_nettype none
module tb_sm3_hash_bit_length_unit;
  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] message_word;
  logic [5:0]  valid_bits;
  logic        is_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          fail_count;
  int          pending_words;
  int          digests_seen;
  int          cycle_count;
  int          words_sent;
  bit          hold_off;

  localparam int CYCLE_LIMIT = 2000000;

  sm3_hash_bit_length_unit i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .message_word(message_word), .valid_bits(valid_bits), .is_last(is_last),
    .out_valid(out_valid), .out_stall(out_stall), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word)
  );

  sm3_digest_checker i_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .message_word(message_word), .valid_bits(valid_bits), .is_last(is_last),
    .out_valid(out_valid), .out_stall(out_stall), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word), .fail_count(fail_count),
    .pending_words(pending_words), .digests_seen(digests_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls, with one long hold-off once a digest is offered
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off && out_valid) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      out_stall <= (n != 0);
      if (n > 1) repeat (n - 1) @(negedge clk);
    end
  end

  // Offer one request and hold it until taken
  task automatic send_word(logic [31:0] wd, logic [5:0] vb, logic lst);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid     <= 1'b1;
    message_word <= wd;
    valid_bits   <= vb;
    is_last      <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // A message of nfull full words and a last word of vb bits
  task automatic send_message(int nfull, logic [5:0] vb);
    for (int i = 0; i < nfull; i++)
      send_word($urandom(), ($urandom_range(0, 7) == 0) ? 6'($urandom()) : 6'd32, 1'b0);
    send_word($urandom(), vb, 1'b1);
  endtask

  initial begin
    int nfull;
    in_valid = 1'b0; message_word = '0; valid_bits = '0; is_last = 1'b0;
    hold_off = 1'b0; cycle_count = 0; words_sent = 0;
    rst = 1'b1;
    repeat (2) @(negedge clk);
    rst = 1'b0;
    // Directed: empty message, extremes, oversized and odd valid-bit counts
    send_word(32'h0, 6'd0, 1'b1);
    send_word(32'hFFFFFFFF, 6'd32, 1'b1);
    send_word(32'hFFFFFFFF, 6'd63, 1'b1);
    send_word(32'hFFFFFFFF, 6'd1, 1'b1);
    send_word(32'h61626300, 6'd24, 1'b1);
    send_word(32'hFFFFFFFF, 6'd5, 1'b0);
    send_word(32'h0, 6'd31, 1'b1);
    send_message(13, 6'd32);
    send_message(14, 6'd0);
    send_message(15, 6'd16);
    // Random messages; one long receiver hold-off to stall the engine
    hold_off = 1'b1;
    while (words_sent < 420) begin
      case ($urandom_range(0, 3))
        0: nfull = $urandom_range(0, 3);
        1: nfull = $urandom_range(12, 18);
        2: nfull = $urandom_range(28, 34);
        default: nfull = $urandom_range(0, 40);
      endcase
      send_message(nfull, ($urandom_range(0, 3) == 0) ? 6'($urandom()) :
                   6'($urandom_range(0, 32)));
    end
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Sent %0d message words; %0d digests checked across empty, partial,", words_sent,
             digests_seen);
    $display("oversized-length and multi-block messages under random stalls.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
